// ===== hw/rtl/ila_pkg.sv =====
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types and constants of the interval list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ila_pkg;

    localparam int MAX_ENTRIES_DEF = 512;
    localparam int MEM_SIZE        = 1024;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ENTRY = 2'd1;
    localparam logic [1:0] ST_NO_MEM   = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [10:0] alloc_size;
        logic [9:0]  free_address;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] block_address;
        logic [9:0] live_count;
    } t_out;

    // one candidate travelling round the ring
    typedef struct packed {
        logic [10:0] cs;      // candidate start (end of its origin entry)
        logic [11:0] ce;      // candidate end
        logic [10:0] ostart;  // start of the origin entry
        logic        live;
        logic        match;   // origin start equals free address
        logic        ovl;     // overlaps some live entry
    } t_ring;

    typedef struct packed {
        logic        load;
        logic        shift;
        logic [10:0] size;
        logic [9:0]  addr;
        logic [10:0] wr_start;
        logic [10:0] wr_end;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_SCAN,
        S_RES
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ila_cell.sv =====
// ----------------------------------------------------------------------------
// ila_cell
// One table entry plus one slot of the candidate ring.
// ----------------------------------------------------------------------------
`default_nettype none

module ila_cell
    import ila_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
) (
    input  wire             i_clk,
    input  wire t_cell_ctl  i_ctl,
    input  wire             i_live,
    input  wire             i_wr,
    input  wire t_ring      i_ring,
    output t_ring           o_ring
);

    logic [10:0] r_start;
    logic [10:0] r_end;
    t_ring       r_ring;
    t_ring       n_ring;

    always_comb begin
        n_ring = r_ring;
        if (i_ctl.load) begin
            if (IS_HEAD) begin
                // the candidate at address zero
                n_ring.cs     = 11'd0;
                n_ring.ce     = {1'b0, i_ctl.size};
                n_ring.ostart = 11'd0;
                n_ring.live   = 1'b1;
                n_ring.match  = 1'b0;
            end else begin
                n_ring.cs     = r_end;
                n_ring.ce     = {1'b0, r_end} + {1'b0, i_ctl.size};
                n_ring.ostart = r_start;
                n_ring.live   = i_live;
                n_ring.match  = i_live && (r_start == {1'b0, i_ctl.addr});
            end
            n_ring.ovl = 1'b0;
        end else if (i_ctl.shift) begin
            n_ring     = i_ring;
            n_ring.ovl = i_ring.ovl | (i_live && (i_ring.cs < r_end) &&
                                       ({1'b0, r_start} < i_ring.ce));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ring <= n_ring;
        if (i_wr) begin
            r_start <= i_ctl.wr_start;
            r_end   <= i_ctl.wr_end;
        end
    end

    assign o_ring = r_ring;

endmodule

`default_nettype wire

// ===== hw/rtl/interval_list_allocator.sv =====
// ----------------------------------------------------------------------------
// interval_list_allocator
// First-fit allocator over a table of live intervals, built as a ring of cells.
// ----------------------------------------------------------------------------
// One transaction in, one result transaction out. The table sits in a row of
// MAX_ENTRIES cells; every cell also holds one slot of a ring of MAX_ENTRIES+1
// candidates (address zero, then the end of each entry). An allocate loads the
// ring, rotates it once so every candidate meets every entry, then rotates it
// again while the head slot is watched for the first fitting candidate. A free
// uses the same passes to find the lowest matching slot and to pick up the last
// entry. An allocate into a full table skips both ring rotations. The input
// is taken again as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_list_allocator
    import ila_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire t_in   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out       o_out_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);   // live count / step counter
    localparam int IW = $clog2(MAX_ENTRIES);       // table index

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_step;
    logic           r_mode, r_full, r_found;
    logic [10:0]    r_size;
    logic [10:0]    r_gs, r_ms, r_me;
    logic [IW-1:0]  r_k;
    t_out           r_out;
    logic           r_out_valid;

    t_ring          w_ring [0:MAX_ENTRIES];
    t_cell_ctl      w_ctl;
    logic           w_acc, w_fire, w_wr_en, w_hit, w_last;
    logic [IW-1:0]  w_widx;
    logic [CW-1:0]  w_step_m1;
    logic [1:0]     w_status;
    t_ring          w_head;

    assign w_acc  = i_in_valid && !o_in_stall;
    assign w_fire = (r_state == S_RES) && (!r_out_valid || !i_out_stall);
    assign w_last = (r_step == CW'(MAX_ENTRIES));
    assign w_head = w_ring[0];

    // first candidate that fits, or for a free the first match
    assign w_hit = (r_mode == MODE_FREE) ? w_head.match :
                   (w_head.live && !w_head.ovl && (w_head.ce <= 12'(MEM_SIZE)));
    assign w_step_m1 = r_step - CW'(1);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if ((i_in_data.mode == MODE_ALLOC) &&
                        (r_count >= CW'(MAX_ENTRIES))) begin
                        n_state = S_RES;
                    end else begin
                        n_state = S_ROT;
                    end
                end
            end
            S_ROT:   if (w_last) n_state = S_SCAN;
            S_SCAN:  if (w_last) n_state = S_RES;
            S_RES:   if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb begin
        w_ctl.load     = 1'b0;
        w_ctl.shift    = 1'b0;
        w_ctl.size     = i_in_data.alloc_size;
        w_ctl.addr     = i_in_data.free_address;
        // commit: an allocate appends at the live count, a free fills the hole
        w_ctl.wr_start = (r_mode == MODE_ALLOC) ? r_gs : r_ms;
        w_ctl.wr_end   = (r_mode == MODE_ALLOC) ? 11'(r_gs + r_size) : r_me;
        unique case (r_state)
            S_IDLE:  w_ctl.load  = w_acc;
            S_ROT:   w_ctl.shift = 1'b1;
            S_SCAN:  w_ctl.shift = 1'b1;
            S_RES:   w_ctl.shift = 1'b0;
            default: w_ctl.shift = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    assign w_widx         = (r_mode == MODE_ALLOC) ? r_count[IW-1:0] : r_k;
    assign w_wr_en        = w_fire && r_found && !r_full;

    always_comb begin
        n_count = r_count;
        if (r_full) begin
            w_status = ST_NO_ENTRY;
        end else if (r_mode == MODE_ALLOC) begin
            w_status = r_found ? ST_OK : ST_NO_MEM;
            if (r_found) n_count = r_count + CW'(1);
        end else begin
            w_status = r_found ? ST_OK : ST_BAD_FREE;
            if (r_found) n_count = r_count - CW'(1);
        end
    end

    // ---- cell row ----
    for (genvar i = 0; i <= MAX_ENTRIES; i++) begin : g_cell
        logic w_live, w_wr;
        if (i == 0) begin : g_head
            assign w_live = 1'b0;
            assign w_wr   = 1'b0;
        end else begin : g_body
            assign w_live = (CW'(i - 1) < r_count);
            assign w_wr   = w_wr_en && (IW'(i - 1) == w_widx);
        end
        ila_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_live (w_live),
            .i_wr   (w_wr),
            .i_ring (w_ring[(i == MAX_ENTRIES) ? 0 : i + 1]),
            .o_ring (w_ring[i])
        );
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_mode  <= i_in_data.mode;
                r_size  <= i_in_data.alloc_size;
                r_full  <= (i_in_data.mode == MODE_ALLOC) &&
                           (r_count >= CW'(MAX_ENTRIES));
                r_found <= 1'b0;
                r_step  <= '0;
            end
            if (r_state == S_ROT || r_state == S_SCAN) begin
                r_step <= w_last ? '0 : r_step + CW'(1);
            end
            // head slot shows ring element r_step during the second pass
            if (r_state == S_SCAN) begin
                if (!r_found && w_hit) begin
                    r_found <= 1'b1;
                    r_gs    <= w_head.cs;
                    r_k     <= w_step_m1[IW-1:0];
                end
                if (r_step == r_count) begin
                    r_ms <= w_head.ostart;
                    r_me <= w_head.cs;
                end
            end
            if (w_fire) begin
                r_out_valid         <= 1'b1;
                r_count             <= n_count;
                r_out.status        <= w_status;
                r_out.block_address <= (w_status == ST_OK && r_mode == MODE_ALLOC) ?
                                       r_gs[9:0] : 10'd0;
                r_out.live_count    <= 10'(n_count);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("live count above table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_in_stall)
        else $error("input taken again straight after a transaction");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.block_address == 10'd0))
        else $error("failed item reports a block address");

endmodule

`default_nettype wire
